### rtl/core/amle_pkg.sv
// ----------------------------------------------------------------------------
// amle_pkg
// types, codes and offset tables shared by the amle hole fill core
// ----------------------------------------------------------------------------
package amle_pkg;

	localparam int MAX_WIDTH     = 256;
	localparam int MAX_HEIGHT    = 256;
	localparam int MAX_NEIGHBORS = 32;
	localparam int TABLE_LEN     = 32;
	localparam int ADDR_W        = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int DIM_W         = 9;
	localparam int VAL_W         = 24;
	localparam int ROOT_W        = 15;
	localparam int NUM_W         = 40;
	localparam int DEN_W         = ROOT_W + 2;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_RUN  = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;

	localparam logic [2:0] REG_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_SWEEPS = 3'd2;
	localparam logic [2:0] REG_NCOUNT = 3'd3;
	localparam logic [2:0] REG_FAR    = 3'd4;

	localparam logic [ROOT_W-1:0] RT1  = 15'd4096;
	localparam logic [ROOT_W-1:0] RT2  = 15'd5793;
	localparam logic [ROOT_W-1:0] RT5  = 15'd9159;
	localparam logic [ROOT_W-1:0] RT10 = 15'd12953;
	localparam logic [ROOT_W-1:0] RT13 = 15'd14768;
	localparam logic [ROOT_W-1:0] RT16 = 15'd16384;
	localparam logic [ROOT_W-1:0] RT17 = 15'd16888;
	localparam logic [ROOT_W-1:0] RT18 = 15'd17378;
	localparam logic [ROOT_W-1:0] RT20 = 15'd18318;

	typedef struct packed {
		logic signed [3:0]   dx;
		logic signed [3:0]   dy;
		logic [ROOT_W-1:0]   root;
	} nb_ent_t;

	typedef struct packed {
		logic                    hole;
		logic signed [VAL_W-1:0] value;
	} pix_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDW, ST_INIT, ST_HOLE, ST_HCHK, ST_NB, ST_NBCHK,
		ST_MUL1, ST_MUL2, ST_DSET, ST_DIV, ST_WB, ST_NEXT, ST_DONE
	} state_t;

	localparam nb_ent_t NEAR_TAB [TABLE_LEN] = '{
		'{4'sd1, 4'sd0, RT1}, '{4'sd0, 4'sd1, RT1}, '{-4'sd1, 4'sd0, RT1}, '{4'sd0, -4'sd1, RT1},
		'{4'sd1, 4'sd1, RT2}, '{-4'sd1, -4'sd1, RT2}, '{-4'sd1, 4'sd1, RT2}, '{4'sd1, -4'sd1, RT2},
		'{4'sd2, 4'sd1, RT5}, '{4'sd1, 4'sd2, RT5}, '{4'sd2, -4'sd1, RT5}, '{4'sd1, -4'sd2, RT5},
		'{-4'sd2, -4'sd1, RT5}, '{-4'sd1, -4'sd2, RT5}, '{-4'sd2, 4'sd1, RT5}, '{-4'sd1, 4'sd2, RT5},
		'{4'sd3, 4'sd1, RT10}, '{4'sd1, 4'sd3, RT10}, '{4'sd3, -4'sd1, RT10}, '{4'sd1, -4'sd3, RT10},
		'{-4'sd3, -4'sd1, RT10}, '{-4'sd1, -4'sd3, RT10}, '{-4'sd3, 4'sd1, RT10},
		'{-4'sd1, 4'sd3, RT10},
		'{4'sd3, 4'sd2, RT13}, '{4'sd2, 4'sd3, RT13}, '{4'sd3, -4'sd2, RT13}, '{4'sd2, -4'sd3, RT13},
		'{-4'sd3, -4'sd2, RT13}, '{-4'sd2, -4'sd3, RT13}, '{-4'sd3, 4'sd2, RT13},
		'{-4'sd2, 4'sd3, RT13}
	};

	localparam nb_ent_t FAR_TAB [TABLE_LEN] = '{
		'{4'sd1, 4'sd0, RT1}, '{4'sd0, 4'sd1, RT1}, '{-4'sd1, 4'sd0, RT1}, '{4'sd0, -4'sd1, RT1},
		'{4'sd1, 4'sd1, RT2}, '{-4'sd1, -4'sd1, RT2}, '{-4'sd1, 4'sd1, RT2}, '{4'sd1, -4'sd1, RT2},
		'{4'sd4, 4'sd0, RT16}, '{-4'sd4, 4'sd0, RT16}, '{4'sd0, 4'sd4, RT16}, '{4'sd0, -4'sd4, RT16},
		'{4'sd4, 4'sd1, RT17}, '{-4'sd4, 4'sd1, RT17}, '{4'sd4, -4'sd1, RT17},
		'{-4'sd4, -4'sd1, RT17},
		'{4'sd1, 4'sd4, RT17}, '{-4'sd1, 4'sd4, RT17}, '{4'sd1, -4'sd4, RT17},
		'{-4'sd1, -4'sd4, RT17},
		'{4'sd4, 4'sd2, RT20}, '{-4'sd4, 4'sd2, RT20}, '{4'sd4, -4'sd2, RT20},
		'{-4'sd4, -4'sd2, RT20},
		'{4'sd2, 4'sd4, RT20}, '{-4'sd2, 4'sd4, RT20}, '{4'sd2, -4'sd4, RT20},
		'{-4'sd2, -4'sd4, RT20},
		'{4'sd3, 4'sd3, RT18}, '{-4'sd3, 4'sd3, RT18}, '{4'sd3, -4'sd3, RT18},
		'{-4'sd3, -4'sd3, RT18}
	};

	function automatic nb_ent_t nb_lookup(input logic far_sel, input logic [4:0] k);
		nb_lookup = far_sel ? FAR_TAB[k] : NEAR_TAB[k];
	endfunction

endpackage

### rtl/core/amle_hole_fill_iteration.sv
// ----------------------------------------------------------------------------
// amle_hole_fill_iteration
// single-scale amle hole filling over an on-chip pixel store
// ----------------------------------------------------------------------------
// load beat: writes the store, result beat registered; read beat: store read, then
// value registered in ST_RDW; run beat: per sweep, each pixel is read, checked and
// stepped; per hole, each neighbor in the table is checked and read if in image,
// then two multiply steps on one shared multiplier and a 40-step divider
// one beat in work at a time; the sequencer sets it
// reset clears the config registers and control; datapath registers and the pixel store are not cleared
// ----------------------------------------------------------------------------
module amle_hole_fill_iteration
	import amle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// pixel_index[15:0], pixel_value[39:16], hole_flag[40], init_value[64:41]
	input  logic [71:0] s_tdata,
	// kind[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// read_value[23:0], max_change[47:24]
	output logic [47:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	state_t state_q, state_d;

	logic [DIM_W-1:0] width_q, height_q;
	logic [15:0]      sweeps_q;
	logic [5:0]       ncount_q;
	logic             far_q;

	pix_t mem [MAX_WIDTH*MAX_HEIGHT];
	pix_t rd_q;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_wa, mem_ra;
	pix_t              mem_wd;

	logic [DIM_W-1:0]  w_eff, h_eff, i_q, j_q;
	logic [ADDR_W-1:0] pos_q;
	logic [15:0]       s_q;
	logic [5:0]        k_q, nn;
	logic              have_q;
	logic signed [VAL_W-1:0] vmin_q, vmax_q, old_q;
	logic [ROOT_W-1:0] rmin_q, rmax_q;
	logic signed [NUM_W-1:0] num_q, prod;
	logic              neg_q;
	logic [NUM_W-1:0]  mag_q;
	logic [DEN_W-1:0]  rem_q, den_q;
	logic [DEN_W:0]    rem_sh;
	logic [5:0]        dcnt_q;
	logic [VAL_W-1:0]  worst_q, diff;
	logic signed [VAL_W-1:0] nv;
	logic              m_valid_q;
	logic [47:0]       m_data_q;

	nb_ent_t           ent;
	logic signed [10:0] ii, jj;
	logic              in_img;
	logic signed [17:0] nb_addr;
	logic              accept, end_row, end_img;
	logic signed [ROOT_W:0] mul_a;
	logic signed [VAL_W-1:0] mul_b;

	assign pready = 1'b1;
	assign w_eff  = (width_q > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : width_q;
	assign h_eff  = (height_q > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : height_q;
	assign nn     = far_q ? 6'(MAX_NEIGHBORS)
	              : ((ncount_q > 6'(MAX_NEIGHBORS)) ? 6'(MAX_NEIGHBORS) : ncount_q);

	assign s_tready = (state_q == ST_IDLE) && (!m_valid_q || m_tready);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// config port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_W'(256);
			height_q <= DIM_W'(256);
			sweeps_q <= 16'd1;
			ncount_q <= 6'd4;
			far_q    <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_WIDTH:  width_q  <= pwdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= pwdata[DIM_W-1:0];
				REG_SWEEPS: sweeps_q <= pwdata[15:0];
				REG_NCOUNT: ncount_q <= pwdata[5:0];
				REG_FAR:    far_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_WIDTH:  prdata = 32'(width_q);
			REG_HEIGHT: prdata = 32'(height_q);
			REG_SWEEPS: prdata = 32'(sweeps_q);
			REG_NCOUNT: prdata = 32'(ncount_q);
			REG_FAR:    prdata = 32'(far_q);
			default:    prdata = 32'd0;
		endcase
	end

	// neighbor geometry
	assign ent     = nb_lookup(far_q, k_q[4:0]);
	assign ii      = $signed({2'b00, i_q}) + 11'(ent.dx);
	assign jj      = $signed({2'b00, j_q}) + 11'(ent.dy);
	assign in_img  = !ii[10] && !jj[10] && (ii < $signed({2'b00, w_eff}))
	               && (jj < $signed({2'b00, h_eff}));
	assign nb_addr = $signed({2'b00, pos_q}) + 18'(ent.dy * $signed({1'b0, w_eff}))
	               + 18'(ent.dx);
	assign end_row = (i_q == w_eff - DIM_W'(1));
	assign end_img = end_row && (j_q == h_eff - DIM_W'(1));

	// shared multiplier
	assign mul_a = (state_q == ST_MUL1) ? $signed({1'b0, rmax_q}) : $signed({1'b0, rmin_q});
	assign mul_b = (state_q == ST_MUL1) ? vmin_q : vmax_q;
	assign prod  = NUM_W'(mul_a * mul_b);

	assign rem_sh = {rem_q, mag_q[NUM_W-1]};
	assign nv     = neg_q ? -$signed(mag_q[VAL_W-1:0]) : $signed(mag_q[VAL_W-1:0]);
	assign diff   = (old_q > nv) ? VAL_W'(old_q - nv) : VAL_W'(nv - old_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && s_tuser == KIND_READ) state_d = ST_RDW;
				else if (accept && s_tuser == KIND_RUN) state_d = ST_INIT;
			end
			ST_RDW:  state_d = ST_IDLE;
			ST_INIT: begin
				if (sweeps_q == 16'd0 || w_eff == '0 || h_eff == '0) state_d = ST_DONE;
				else state_d = ST_HOLE;
			end
			ST_HOLE: state_d = ST_HCHK;
			ST_HCHK: state_d = (rd_q.hole && nn != 6'd0) ? ST_NB : ST_NEXT;
			ST_NB: begin
				if (k_q == nn) state_d = have_q ? ST_MUL1 : ST_NEXT;
				else if (in_img) state_d = ST_NBCHK;
			end
			ST_NBCHK: state_d = ST_NB;
			ST_MUL1:  state_d = ST_MUL2;
			ST_MUL2:  state_d = ST_DSET;
			ST_DSET:  state_d = ST_DIV;
			ST_DIV:   if (dcnt_q == 6'(NUM_W - 1)) state_d = ST_WB;
			ST_WB:    state_d = ST_NEXT;
			ST_NEXT: begin
				if (end_img && (s_q + 16'd1 == sweeps_q)) state_d = ST_DONE;
				else state_d = ST_HOLE;
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// store port controls
	always_comb begin
		mem_we = 1'b0;
		mem_wa = s_tdata[15:0];
		mem_wd = '{hole: s_tdata[40], value: s_tdata[40] ? s_tdata[64:41] : s_tdata[39:16]};
		mem_ra = s_tdata[15:0];
		case (state_q)
			ST_IDLE: mem_we = accept && s_tuser == KIND_LOAD;
			ST_HOLE: mem_ra = pos_q;
			ST_NB:   mem_ra = nb_addr[ADDR_W-1:0];
			ST_WB: begin
				mem_we = 1'b1;
				mem_wa = pos_q;
				mem_wd = '{hole: 1'b1, value: nv};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_valid_q && m_tready) m_valid_q <= 1'b0;
			if ((state_q == ST_IDLE && accept && s_tuser != KIND_READ && s_tuser != KIND_RUN)
			    || state_q == ST_RDW || state_q == ST_DONE)
				m_valid_q <= 1'b1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (accept) m_data_q <= '0;
			ST_RDW:  m_data_q <= {24'd0, rd_q.value};
			ST_INIT: begin
				s_q <= '0; i_q <= '0; j_q <= '0; pos_q <= '0; worst_q <= '0;
			end
			ST_HCHK: begin
				k_q <= '0; have_q <= 1'b0; old_q <= rd_q.value;
			end
			ST_NB: if (k_q != nn && !in_img) k_q <= k_q + 6'd1;
			ST_NBCHK: begin
				if (!have_q || rd_q.value < vmin_q) begin
					vmin_q <= rd_q.value; rmin_q <= ent.root;
				end
				if (!have_q || rd_q.value > vmax_q) begin
					vmax_q <= rd_q.value; rmax_q <= ent.root;
				end
				have_q <= 1'b1;
				k_q    <= k_q + 6'd1;
			end
			ST_MUL1: num_q <= prod;
			ST_MUL2: num_q <= num_q + prod;
			ST_DSET: begin
				neg_q  <= num_q[NUM_W-1];
				mag_q  <= num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
				rem_q  <= '0;
				den_q  <= DEN_W'(rmax_q) + DEN_W'(rmin_q);
				dcnt_q <= '0;
			end
			ST_DIV: begin
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q <= DEN_W'(rem_sh - {1'b0, den_q});
					mag_q <= {mag_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[DEN_W-1:0];
					mag_q <= {mag_q[NUM_W-2:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 6'd1;
			end
			ST_WB: if (diff > worst_q) worst_q <= diff;
			ST_NEXT: begin
				if (end_img) begin
					s_q <= s_q + 16'd1; i_q <= '0; j_q <= '0; pos_q <= '0;
					if (s_q + 16'd1 != sweeps_q) worst_q <= '0;
				end else begin
					pos_q <= pos_q + ADDR_W'(1);
					if (end_row) begin
						i_q <= '0; j_q <= j_q + DIM_W'(1);
					end else begin
						i_q <= i_q + DIM_W'(1);
					end
				end
			end
			ST_DONE: m_data_q <= {worst_q, 24'd0};
			default: ;
		endcase
	end

endmodule
